// ----- rtl/fucc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Update-command checker package
// Beat types, command and answer codes, and register indexes shared by the
// front, queue, back and top level of the update-command checker.
// ----------------------------------------------------------------------------
package fucc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned SID_W  = 8;
    localparam int unsigned CFG_W  = 3;

    localparam logic [2:0] NUM_SECTORS = 3'd4;

    localparam logic [2:0] CMD_GET_INFO = 3'd0;
    localparam logic [2:0] CMD_BEGIN    = 3'd1;
    localparam logic [2:0] CMD_WRITE    = 3'd2;
    localparam logic [2:0] CMD_END      = 3'd3;
    localparam logic [2:0] CMD_REBOOT   = 3'd4;

    localparam logic [CFG_W-1:0] CFG_SECTOR_COUNT    = 3'd0;
    localparam logic [CFG_W-1:0] CFG_BOOTED_SECTOR   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_METADATA_SECTOR = 3'd2;
    localparam logic [CFG_W-1:0] CFG_SECTOR0_BYTES   = 3'd3;
    localparam logic [CFG_W-1:0] CFG_SECTOR1_BYTES   = 3'd4;
    localparam logic [CFG_W-1:0] CFG_SECTOR2_BYTES   = 3'd5;
    localparam logic [CFG_W-1:0] CFG_SECTOR3_BYTES   = 3'd6;

    typedef enum logic [2:0] {
        OP_INFO,
        OP_BEGIN,
        OP_WRITE,
        OP_END,
        OP_REBOOT,
        OP_BAD
    } t_op;

    typedef enum logic [2:0] {
        KIND_INFO,
        KIND_BEGIN,
        KIND_WRITE,
        KIND_END,
        KIND_REBOOT,
        KIND_ERROR
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE,
        ERR_INVALID,
        ERR_BOOTED_SECTOR,
        ERR_BAD_SECTOR,
        ERR_METADATA_SECTOR,
        ERR_SIZE_OVERFLOW,
        ERR_SECTOR_MISMATCH,
        ERR_TOTAL_MISMATCH,
        ERR_PAYLOAD_MISMATCH,
        ERR_CHUNK_OVER_TOTAL,
        ERR_OFFSET_MISMATCH,
        ERR_OFFSET_BEYOND,
        ERR_WRITE_OVERFLOW
    } t_err;

    typedef struct packed {
        logic [2:0]        command;
        logic [SID_W-1:0]  sector_id;
        logic [WORD_W-1:0] total_bytes;
        logic [WORD_W-1:0] chunk_offset;
        logic [WORD_W-1:0] chunk_bytes;
        logic [WORD_W-1:0] payload_bytes;
    } t_cmd_beat;

    typedef struct packed {
        logic [2:0]        answer_kind;
        logic [3:0]        error_code;
        logic [SID_W-1:0]  answer_sector;
        logic [WORD_W-1:0] answer_amount;
        logic [WORD_W-1:0] flash_offset;
        logic [WORD_W-1:0] flash_length;
    } t_ans_beat;

    typedef struct packed {
        t_op               op;
        t_err              pre_err;
        logic [SID_W-1:0]  sector_id;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] offset;
        logic [WORD_W-1:0] length;
    } t_cls;

endpackage
`default_nettype wire

// ----- rtl/firmware_update_command_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Update-command checker
// Command beats enter on the i_cmd channel and answer beats leave on the
// o_ans channel, both valid/ready; registers are written on the cfg channel,
// which is always ready; the user must see that it is written only while the
// block is idle, which the block itself does not enforce. Every command beat
// gives exactly one answer beat, in order. The front classifies a beat
// against the sector table as it is accepted and places it in a
// QUEUE_DEPTH-entry queue. The back takes one beat per cycle from the queue
// while its answer register is empty or being taken, checks it against the
// transfer state and loads the answer register. Throughput is one beat per
// cycle while the receiver takes every answer.
// When the receiver stalls, the answer register holds, the queue fills and
// o_cmd_ready falls once QUEUE_DEPTH beats wait.
// Reset empties the queue and the answer register, returns the block to
// idle with a cleared transfer state, and restores the default sector table.
// ----------------------------------------------------------------------------
module firmware_update_command_checker
    import fucc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    output logic                   o_cmd_ready,
    input  wire t_cmd_beat         i_cmd,
    output logic                   o_ans_valid,
    input  wire logic              i_ans_ready,
    output t_ans_beat              o_ans,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_index,
    input  wire logic [WORD_W-1:0] i_cfg_data
);

    t_cls w_front_cls;
    t_cls w_queue_cls;
    logic w_queue_not_empty;
    logic w_queue_pop;

    fucc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .o_cls       (w_front_cls)
    );

    fucc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_cmd_valid),
        .o_not_full  (o_cmd_ready),
        .i_data      (w_front_cls),
        .o_not_empty (w_queue_not_empty),
        .i_pop       (w_queue_pop),
        .o_data      (w_queue_cls)
    );

    fucc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (w_queue_not_empty),
        .o_cls_pop   (w_queue_pop),
        .i_cls       (w_queue_cls),
        .o_ans_valid (o_ans_valid),
        .i_ans_ready (i_ans_ready),
        .o_ans       (o_ans)
    );

`ifndef ASSERT_OFF
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_queue_not_empty && (!o_ans_valid || i_ans_ready)) |=> o_ans_valid)
        else $error("queued beat did not reach the answer register");

    a_write_amount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ans_valid && o_ans.answer_kind == KIND_WRITE) |->
        (o_ans.answer_amount == o_ans.flash_offset + o_ans.flash_length))
        else $error("write answer position does not follow its chunk");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ans_valid && o_ans.answer_kind == KIND_ERROR) |->
        (o_ans.error_code != ERR_NONE && o_ans.flash_length == '0
         && o_ans.answer_amount == '0))
        else $error("error answer carries values");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_cmd_ready) |-> w_queue_not_empty)
        else $error("command channel stalled with an empty queue");
`endif

endmodule
`default_nettype wire

// ----- rtl/fucc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Update-command checker front
// Holds the configuration registers and classifies each command beat,
// settling every check that depends on the sector table alone.
// ----------------------------------------------------------------------------
module fucc_front
    import fucc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_W-1:0]  i_cfg_index,
    input  wire logic [WORD_W-1:0] i_cfg_data,
    input  wire t_cmd_beat         i_cmd,
    output t_cls                   o_cls
);

    logic [2:0]        r_sector_count;
    logic [1:0]        r_booted_sector;
    logic [1:0]        r_metadata_sector;
    logic [WORD_W-1:0] r_sector_bytes [4];
    logic [2:0]        w_valid_sectors;
    t_err              w_begin_err;
    t_err              w_reboot_err;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector_count    <= NUM_SECTORS;
            r_booted_sector   <= 2'd0;
            r_metadata_sector <= 2'd1;
            r_sector_bytes[0] <= 32'd101376;
            r_sector_bytes[1] <= 32'd1024;
            r_sector_bytes[2] <= 32'd204800;
            r_sector_bytes[3] <= 32'd16384;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SECTOR_COUNT:    r_sector_count    <= i_cfg_data[2:0];
                CFG_BOOTED_SECTOR:   r_booted_sector   <= i_cfg_data[1:0];
                CFG_METADATA_SECTOR: r_metadata_sector <= i_cfg_data[1:0];
                CFG_SECTOR0_BYTES:   r_sector_bytes[0] <= i_cfg_data;
                CFG_SECTOR1_BYTES:   r_sector_bytes[1] <= i_cfg_data;
                CFG_SECTOR2_BYTES:   r_sector_bytes[2] <= i_cfg_data;
                CFG_SECTOR3_BYTES:   r_sector_bytes[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_valid_sectors = (r_sector_count > NUM_SECTORS) ? NUM_SECTORS : r_sector_count;

    always_comb begin
        if (i_cmd.sector_id == {6'd0, r_booted_sector}) begin
            w_begin_err = ERR_BOOTED_SECTOR;
        end else if (i_cmd.sector_id >= {5'd0, w_valid_sectors}) begin
            w_begin_err = ERR_BAD_SECTOR;
        end else if (i_cmd.sector_id == {6'd0, r_metadata_sector}) begin
            w_begin_err = ERR_METADATA_SECTOR;
        end else if (i_cmd.total_bytes > r_sector_bytes[i_cmd.sector_id[1:0]]) begin
            w_begin_err = ERR_SIZE_OVERFLOW;
        end else begin
            w_begin_err = ERR_NONE;
        end
    end

    assign w_reboot_err = (i_cmd.sector_id >= {5'd0, w_valid_sectors}) ? ERR_BAD_SECTOR
                                                                       : ERR_NONE;

    always_comb begin
        o_cls.sector_id = i_cmd.sector_id;
        o_cls.total     = i_cmd.total_bytes;
        o_cls.offset    = i_cmd.chunk_offset;
        o_cls.length    = i_cmd.chunk_bytes;
        o_cls.pre_err   = ERR_NONE;
        case (i_cmd.command)
            CMD_GET_INFO: begin
                o_cls.op = OP_INFO;
            end
            CMD_BEGIN: begin
                o_cls.op      = OP_BEGIN;
                o_cls.pre_err = w_begin_err;
            end
            CMD_WRITE: begin
                o_cls.op      = OP_WRITE;
                o_cls.pre_err = (i_cmd.chunk_bytes != i_cmd.payload_bytes)
                              ? ERR_PAYLOAD_MISMATCH : ERR_NONE;
            end
            CMD_END: begin
                o_cls.op = OP_END;
            end
            CMD_REBOOT: begin
                o_cls.op      = OP_REBOOT;
                o_cls.pre_err = w_reboot_err;
            end
            default: begin
                o_cls.op = OP_BAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/fucc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Update-command checker queue
// A short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module fucc_queue
    import fucc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_not_full,
    input  wire t_cls i_data,
    output logic      o_not_empty,
    input  wire logic i_pop,
    output t_cls      o_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_not_full  = (r_count != CNT_W'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/fucc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Update-command checker back
// Keeps the transfer state, runs the checks that depend on it, and holds
// each answer in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module fucc_back
    import fucc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cls_valid,
    output logic      o_cls_pop,
    input  wire t_cls i_cls,
    output logic      o_ans_valid,
    input  wire logic i_ans_ready,
    output t_ans_beat o_ans
);

    logic              r_writing;
    logic [1:0]        r_active_sector;
    logic [WORD_W-1:0] r_total;
    logic [WORD_W-1:0] r_position;
    logic              r_ans_valid;
    t_ans_beat         r_ans;

    logic              n_writing;
    logic [1:0]        n_active_sector;
    logic [WORD_W-1:0] n_total;
    logic [WORD_W-1:0] n_position;
    t_ans_beat         n_ans;
    t_err              w_err;
    logic [WORD_W-1:0] w_end_pos;

    assign o_cls_pop   = i_cls_valid && (!r_ans_valid || i_ans_ready);
    assign o_ans_valid = r_ans_valid;
    assign o_ans       = r_ans;
    assign w_end_pos   = i_cls.offset + i_cls.length;

    always_comb begin
        n_writing       = r_writing;
        n_active_sector = r_active_sector;
        n_total         = r_total;
        n_position      = r_position;
        n_ans           = '0;
        w_err           = ERR_NONE;
        case (i_cls.op)
            OP_INFO: begin
                n_ans.answer_kind = KIND_INFO;
            end
            OP_BEGIN: begin
                w_err = i_cls.pre_err;
                if (w_err == ERR_NONE) begin
                    n_writing           = 1'b1;
                    n_active_sector     = i_cls.sector_id[1:0];
                    n_total             = i_cls.total;
                    n_position          = '0;
                    n_ans.answer_kind   = KIND_BEGIN;
                    n_ans.answer_sector = i_cls.sector_id;
                    n_ans.answer_amount = i_cls.total;
                end
            end
            OP_WRITE: begin
                if (!r_writing) begin
                    w_err = ERR_INVALID;
                end else if (i_cls.pre_err != ERR_NONE) begin
                    w_err = i_cls.pre_err;
                end else if (i_cls.length > r_total) begin
                    w_err = ERR_CHUNK_OVER_TOTAL;
                end else if (i_cls.offset != r_position) begin
                    w_err = ERR_OFFSET_MISMATCH;
                end else if (i_cls.offset >= r_total) begin
                    w_err = ERR_OFFSET_BEYOND;
                end else if (i_cls.offset > r_total - i_cls.length) begin
                    w_err = ERR_WRITE_OVERFLOW;
                end
                if (w_err == ERR_NONE) begin
                    n_position          = w_end_pos;
                    n_ans.answer_kind   = KIND_WRITE;
                    n_ans.answer_amount = w_end_pos;
                    n_ans.flash_offset  = i_cls.offset;
                    n_ans.flash_length  = i_cls.length;
                end
            end
            OP_END: begin
                if (i_cls.sector_id != {6'd0, r_active_sector}) begin
                    w_err = ERR_SECTOR_MISMATCH;
                end else if (i_cls.total != r_total) begin
                    w_err = ERR_TOTAL_MISMATCH;
                end
                if (w_err == ERR_NONE) begin
                    n_writing           = 1'b0;
                    n_ans.answer_kind   = KIND_END;
                    n_ans.answer_amount = r_total;
                end
            end
            OP_REBOOT: begin
                w_err = r_writing ? ERR_INVALID : i_cls.pre_err;
                if (w_err == ERR_NONE) begin
                    n_ans.answer_kind   = KIND_REBOOT;
                    n_ans.answer_sector = i_cls.sector_id;
                end
            end
            default: begin
                w_err = ERR_INVALID;
            end
        endcase
        if (w_err != ERR_NONE) begin
            n_ans             = '0;
            n_ans.answer_kind = KIND_ERROR;
            n_ans.error_code  = w_err;
            n_writing         = r_writing;
            n_active_sector   = r_active_sector;
            n_total           = r_total;
            n_position        = r_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_writing       <= 1'b0;
            r_active_sector <= 2'd0;
            r_total         <= '0;
            r_position      <= '0;
            r_ans_valid     <= 1'b0;
        end else begin
            if (o_cls_pop) begin
                r_writing       <= n_writing;
                r_active_sector <= n_active_sector;
                r_total         <= n_total;
                r_position      <= n_position;
                r_ans_valid     <= 1'b1;
            end else if (i_ans_ready) begin
                r_ans_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_pop) begin
            r_ans <= n_ans;
        end
    end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Update-command checker testbench
// Drives command beats and register writes into the checker and predicts
// every answer beat from a model of the sector table and the transfer state
// that is kept here. Answers are compared field by field in order. The run
// has a directed part, a sweep of register settings, random transfers under
// several idling patterns, and a back-pressure test.
// ----------------------------------------------------------------------------
module tb;
    import fucc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [2:0] CMD_TOP = 3'b111;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cmd_valid = 1'b0;
    logic              o_cmd_ready;
    t_cmd_beat         i_cmd = '0;
    logic              o_ans_valid;
    logic              i_ans_ready = 1'b0;
    t_ans_beat         o_ans;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_index = '0;
    logic [WORD_W-1:0] i_cfg_data = '0;

    wire cmd_fire = i_cmd_valid && o_cmd_ready;
    wire ans_fire = o_ans_valid && i_ans_ready;
    wire cfg_fire = i_cfg_valid && o_cfg_ready;

    logic [2:0]        reg_count;
    logic [1:0]        reg_booted;
    logic [1:0]        reg_meta;
    logic [WORD_W-1:0] reg_size [4];

    logic              xfer_writing;
    logic [1:0]        xfer_sector;
    logic [WORD_W-1:0] xfer_total;
    logic [WORD_W-1:0] xfer_pos;

    t_ans_beat   expected_answers[$];
    int unsigned answer_errors = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned hold_left = 0;

    firmware_update_command_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_ans_valid (o_ans_valid),
        .i_ans_ready (i_ans_ready),
        .o_ans       (o_ans),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_ans_beat predict_answer(input t_cmd_beat c);
        t_ans_beat  a;
        logic [2:0] nsec;
        a = '0;
        a.answer_kind = KIND_ERROR;
        nsec = (reg_count > NUM_SECTORS) ? NUM_SECTORS : reg_count;
        case (c.command)
            CMD_GET_INFO: begin
                a.answer_kind = KIND_INFO;
            end
            CMD_BEGIN: begin
                if (c.sector_id == {6'd0, reg_booted}) begin
                    a.error_code = ERR_BOOTED_SECTOR;
                end else if (c.sector_id >= {5'd0, nsec}) begin
                    a.error_code = ERR_BAD_SECTOR;
                end else if (c.sector_id == {6'd0, reg_meta}) begin
                    a.error_code = ERR_METADATA_SECTOR;
                end else if (c.total_bytes > reg_size[c.sector_id[1:0]]) begin
                    a.error_code = ERR_SIZE_OVERFLOW;
                end else begin
                    xfer_pos = '0;
                    xfer_total = c.total_bytes;
                    xfer_sector = c.sector_id[1:0];
                    xfer_writing = 1'b1;
                    a.answer_kind = KIND_BEGIN;
                    a.answer_sector = c.sector_id;
                    a.answer_amount = c.total_bytes;
                end
            end
            CMD_WRITE: begin
                if (!xfer_writing) begin
                    a.error_code = ERR_INVALID;
                end else if (c.chunk_bytes != c.payload_bytes) begin
                    a.error_code = ERR_PAYLOAD_MISMATCH;
                end else if (c.chunk_bytes > xfer_total) begin
                    a.error_code = ERR_CHUNK_OVER_TOTAL;
                end else if (c.chunk_offset != xfer_pos) begin
                    a.error_code = ERR_OFFSET_MISMATCH;
                end else if (c.chunk_offset >= xfer_total) begin
                    a.error_code = ERR_OFFSET_BEYOND;
                end else if (c.chunk_offset > xfer_total - c.chunk_bytes) begin
                    a.error_code = ERR_WRITE_OVERFLOW;
                end else begin
                    xfer_pos = c.chunk_offset + c.chunk_bytes;
                    a.answer_kind = KIND_WRITE;
                    a.answer_amount = xfer_pos;
                    a.flash_offset = c.chunk_offset;
                    a.flash_length = c.chunk_bytes;
                end
            end
            CMD_END: begin
                if (c.sector_id != {6'd0, xfer_sector}) begin
                    a.error_code = ERR_SECTOR_MISMATCH;
                end else if (c.total_bytes != xfer_total) begin
                    a.error_code = ERR_TOTAL_MISMATCH;
                end else begin
                    xfer_writing = 1'b0;
                    a.answer_kind = KIND_END;
                    a.answer_amount = xfer_total;
                end
            end
            CMD_REBOOT: begin
                if (xfer_writing) begin
                    a.error_code = ERR_INVALID;
                end else if (c.sector_id >= {5'd0, nsec}) begin
                    a.error_code = ERR_BAD_SECTOR;
                end else begin
                    a.answer_kind = KIND_REBOOT;
                    a.answer_sector = c.sector_id;
                end
            end
            default: begin
                a.error_code = ERR_INVALID;
            end
        endcase
        return a;
    endfunction

    always @(posedge i_clk) begin : answer_monitor
        t_ans_beat want;
        logic      bad;
        if (!i_rst_n) begin
            reg_count = NUM_SECTORS;
            reg_booted = 2'd0;
            reg_meta = 2'd1;
            reg_size[0] = 32'd101376;
            reg_size[1] = 32'd1024;
            reg_size[2] = 32'd204800;
            reg_size[3] = 32'd16384;
            xfer_writing = 1'b0;
            xfer_sector = '0;
            xfer_total = '0;
            xfer_pos = '0;
            expected_answers.delete();
        end else begin
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_SECTOR_COUNT:    reg_count = i_cfg_data[2:0];
                    CFG_BOOTED_SECTOR:   reg_booted = i_cfg_data[1:0];
                    CFG_METADATA_SECTOR: reg_meta = i_cfg_data[1:0];
                    CFG_SECTOR0_BYTES:   reg_size[0] = i_cfg_data;
                    CFG_SECTOR1_BYTES:   reg_size[1] = i_cfg_data;
                    CFG_SECTOR2_BYTES:   reg_size[2] = i_cfg_data;
                    CFG_SECTOR3_BYTES:   reg_size[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (cmd_fire) begin
                expected_answers.push_back(predict_answer(i_cmd));
            end
            if (ans_fire) begin
                if (expected_answers.size() == 0) begin
                    answer_errors++;
                    if (answer_errors <= 10) begin
                        $display("Answer beat with no command waiting: kind %0d error %0d",
                                 o_ans.answer_kind, o_ans.error_code);
                    end
                end else begin
                    want = expected_answers.pop_front();
                    bad = (o_ans.answer_kind !== want.answer_kind)
                       || (o_ans.error_code !== want.error_code)
                       || (o_ans.answer_sector !== want.answer_sector)
                       || (o_ans.answer_amount !== want.answer_amount)
                       || (o_ans.flash_offset !== want.flash_offset)
                       || (o_ans.flash_length !== want.flash_length);
                    if (bad) begin
                        answer_errors++;
                        if (answer_errors <= 10) begin
                            $display("Answer mismatch at %0t: expected kind %0d err %0d sec %0d",
                                     $realtime, want.answer_kind, want.error_code,
                                     want.answer_sector);
                            $display("  amount %h offset %h length %h",
                                     want.answer_amount, want.flash_offset,
                                     want.flash_length);
                            $display("  got kind %0d err %0d sec %0d amount %h offset %h length %h",
                                     o_ans.answer_kind, o_ans.error_code,
                                     o_ans.answer_sector, o_ans.answer_amount,
                                     o_ans.flash_offset, o_ans.flash_length);
                        end
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_ans_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ans_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cmd_fire || ans_fire || cfg_fire) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL firmware_update_command_checker");
                $finish;
            end
        end
    end

    function automatic t_cmd_beat mk_cmd(input logic [2:0] op, input logic [SID_W-1:0] sid,
                                         input logic [WORD_W-1:0] total,
                                         input logic [WORD_W-1:0] off,
                                         input logic [WORD_W-1:0] len,
                                         input logic [WORD_W-1:0] pay);
        t_cmd_beat c;
        c.command = op;
        c.sector_id = sid;
        c.total_bytes = total;
        c.chunk_offset = off;
        c.chunk_bytes = len;
        c.payload_bytes = pay;
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(input t_cmd_beat c);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) gap++;
        @(negedge i_clk);
        if (gap != 0) begin
            i_cmd_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd_valid <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (!o_cmd_ready);
        items_sent++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_cmd_valid <= 1'b0;
        do @(posedge i_clk); while (expected_answers.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [2:0] count, input logic [1:0] booted,
                                 input logic [1:0] meta, input logic [WORD_W-1:0] s0,
                                 input logic [WORD_W-1:0] s1, input logic [WORD_W-1:0] s2,
                                 input logic [WORD_W-1:0] s3);
        wait_drain();
        write_reg(CFG_SECTOR_COUNT, {29'd0, count});
        write_reg(CFG_BOOTED_SECTOR, {30'd0, booted});
        write_reg(CFG_METADATA_SECTOR, {30'd0, meta});
        write_reg(CFG_SECTOR0_BYTES, s0);
        write_reg(CFG_SECTOR1_BYTES, s1);
        write_reg(CFG_SECTOR2_BYTES, s2);
        write_reg(CFG_SECTOR3_BYTES, s3);
    endtask

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        snd_idle_pct = snd;
        rcv_stall_pct = rcv;
    endtask

    task automatic send_noise();
        send_cmd(mk_cmd(3'($urandom_range(CMD_TOP)), SID_W'($urandom_range(255)),
                        rand_word(), rand_word(), rand_word(), rand_word()));
    endtask

    // One transfer: begin, a few chunks and an end, with occasional flaws
    // so that every error of the write path is reached from a live transfer.
    task automatic run_transfer();
        logic [WORD_W-1:0] cap, total, pos, rest, len, off, pay;
        logic [SID_W-1:0]  sid;
        logic [2:0]        nsec;
        int unsigned       flaw;
        logic [SID_W-1:0]  picks[$];
        nsec = (reg_count > NUM_SECTORS) ? NUM_SECTORS : reg_count;
        for (int s = 0; s < int'(nsec); s++) begin
            if (s != int'(reg_booted) && s != int'(reg_meta)) picks.push_back(SID_W'(s));
        end
        if (picks.size() == 0) begin
            send_noise();
            return;
        end
        sid = picks[$urandom_range(picks.size() - 1)];
        cap = reg_size[sid[1:0]];
        case ($urandom_range(9))
            0: total = '0;
            1: total = cap;
            2: total = $urandom_range(cap);
            default: total = $urandom_range((cap < 4096) ? cap : 4096);
        endcase
        if ($urandom_range(9) == 0 && cap != '1) total = cap + 1;
        send_cmd(mk_cmd(CMD_BEGIN, sid, total, rand_word(), rand_word(), rand_word()));
        pos = '0;
        repeat ($urandom_range(1, 6)) begin
            rest = total - pos;
            len = ($urandom_range(2) == 0) ? rest : $urandom_range(rest);
            off = pos;
            pay = len;
            flaw = $urandom_range(19);
            case (flaw)
                0: pay = len ^ (32'd1 << $urandom_range(31));
                1: off = pos + 1 + $urandom_range(15);
                2: if (rest != '1) begin
                    len = rest + 1;
                    pay = len;
                end
                3: if (total != '1) begin
                    len = total + 1 + $urandom_range(7);
                    pay = len;
                end
                4: off = rand_word();
                5: send_cmd(mk_cmd(CMD_GET_INFO, SID_W'($urandom_range(255)), rand_word(),
                                   rand_word(), rand_word(), rand_word()));
                6: send_cmd(mk_cmd(CMD_REBOOT, SID_W'($urandom_range(3)), rand_word(),
                                   rand_word(), rand_word(), rand_word()));
                default: ;
            endcase
            send_cmd(mk_cmd(CMD_WRITE, SID_W'($urandom_range(255)), rand_word(), off, len,
                            pay));
            if (off == pos && pay == len && len <= rest && rest != 0) pos = pos + len;
        end
        case ($urandom_range(9))
            0: send_cmd(mk_cmd(CMD_END, SID_W'(sid + 1 + $urandom_range(254)), total,
                               rand_word(), rand_word(), rand_word()));
            1: send_cmd(mk_cmd(CMD_END, sid, total ^ (32'd1 << $urandom_range(31)),
                               rand_word(), rand_word(), rand_word()));
            2: ;
            default: send_cmd(mk_cmd(CMD_END, sid, total, rand_word(), rand_word(),
                                     rand_word()));
        endcase
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned first;
        first = items_sent;
        while (items_sent - first < n) begin
            if ($urandom_range(99) < 75) run_transfer();
            else send_noise();
        end
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_cmd(mk_cmd(CMD_GET_INFO, 8'd0, '0, '0, '0, '0));
        for (int c = int'(CMD_REBOOT) + 1; c <= int'(CMD_TOP); c++) begin
            send_cmd(mk_cmd(3'(c), 8'd2, '1, '1, '1, '1));
        end
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_END, 8'd0, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_END, 8'd1, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_REBOOT, 8'd2, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_REBOOT, 8'd4, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_REBOOT, 8'd255, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_BEGIN, 8'd0, 32'd16, '0, '0, '0));
        send_cmd(mk_cmd(CMD_BEGIN, 8'd4, 32'd16, '0, '0, '0));
        send_cmd(mk_cmd(CMD_BEGIN, 8'd1, 32'd16, '0, '0, '0));
        send_cmd(mk_cmd(CMD_BEGIN, 8'd2, 32'd204801, '0, '0, '0));
        send_cmd(mk_cmd(CMD_BEGIN, 8'd2, 32'd204800, '0, '0, '0));
        send_cmd(mk_cmd(CMD_REBOOT, 8'd2, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, '0, 32'd10, 32'd11));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, '0, 32'd204801, 32'd204801));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, 32'd4, 32'd10, 32'd10));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, '0, 32'd100, 32'd100));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, 32'd100, '0, '0));
        send_cmd(mk_cmd(CMD_BEGIN, 8'd3, 32'd100, '0, '0, '0));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, '0, 32'd60, 32'd60));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, 32'd60, 32'd50, 32'd50));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, 32'd60, 32'd40, 32'd40));
        send_cmd(mk_cmd(CMD_WRITE, 8'd0, '0, 32'd100, '0, '0));
        send_cmd(mk_cmd(CMD_END, 8'd2, 32'd100, '0, '0, '0));
        send_cmd(mk_cmd(CMD_END, 8'd3, 32'd99, '0, '0, '0));
        send_cmd(mk_cmd(CMD_END, 8'd3, 32'd100, '0, '0, '0));
        send_cmd(mk_cmd(CMD_REBOOT, 8'd3, '0, '0, '0, '0));
    endtask

    task automatic test_register_extremes();
        apply_setting(3'd0, 2'd3, 2'd2, '0, '0, '0, '0);
        set_idling(0, 0);
        send_cmd(mk_cmd(CMD_BEGIN, 8'd0, '0, '0, '0, '0));
        send_cmd(mk_cmd(CMD_REBOOT, 8'd0, '0, '0, '0, '0));
        run_random(40);
        apply_setting(3'd1, 2'd3, 2'd2, '0, '1, '1, '1);
        set_idling(81, 0);
        run_random(50);
        apply_setting(NUM_SECTORS, 2'd0, 2'd3, '1, '1, '1, '1);
        set_idling(0, 81);
        run_random(60);
        apply_setting(CMD_TOP, 2'd1, 2'd0, 32'd1, 32'd17, 32'd4096, '1);
        set_idling(23, 23);
        run_random(60);
        apply_setting(3'd5, 2'd2, 2'd2, $urandom, $urandom, $urandom, $urandom);
        set_idling(0, 0);
        run_random(60);
        apply_setting(NUM_SECTORS, 2'd0, 2'd1, 32'd101376, 32'd1024, 32'd204800,
                      32'd16384);
    endtask

    task automatic test_idling_phases();
        set_idling(0, 0);
        run_random(300);
        set_idling(81, 0);
        run_random(300);
        set_idling(0, 81);
        run_random(300);
        set_idling(23, 23);
        run_random(300);
    endtask

    task automatic test_backpressure();
        wait_drain();
        set_idling(0, 0);
        hold_left = 150;
        run_random(40);
        wait_drain();
        set_idling(23, 0);
        hold_left = 80;
        run_random(40);
        wait_drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_idling_phases();
        test_backpressure();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (answer_errors == 0 && expected_answers.size() == 0) begin
            $display("PASS firmware_update_command_checker");
        end else begin
            $display("FAIL firmware_update_command_checker");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fucc_pkg.sv
rtl/fucc_front.sv
rtl/fucc_queue.sv
rtl/fucc_back.sv
rtl/firmware_update_command_checker.sv
tb/tb.sv
